// ===== rtl/window_rect_screen_clamp_core_macros.svh =====
// assertion macros for the placement core
`ifndef WINDOW_RECT_SCREEN_CLAMP_CORE_MACROS_SVH
`define WINDOW_RECT_SCREEN_CLAMP_CORE_MACROS_SVH
// implication checked on every clock, off during reset
`define WRSC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wrsc check failed");
// implication whose consequent is checked in the next cycle
`define WRSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wrsc check failed");
`endif

// ===== rtl/wrsc_pkg.sv =====
package wrsc_pkg;
	localparam int DEF_MAX_SCREENS = 8;
	localparam int DEF_COORD_BITS  = 16;
	localparam int CFG_BITS        = 15;
	localparam int CMD_BITS        = 2;
	localparam int STATUS_BITS     = 3;
	localparam int IDX_OUT_BITS    = 3;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ADD   = 2'd1;
	localparam logic [1:0] CMD_PLACE = 2'd2;
	localparam logic [1:0] CMD_PLACE_ALT = 2'd3;

	localparam logic [2:0] ST_PLACED  = 3'd0;
	localparam logic [2:0] ST_PASS    = 3'd1;
	localparam logic [2:0] ST_ADDED   = 3'd2;
	localparam logic [2:0] ST_INVALID = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;
	localparam logic [2:0] ST_CLEARED = 3'd5;

	localparam logic CFG_MIN_W = 1'b0;
	localparam logic CFG_MIN_H = 1'b1;
endpackage

// ===== rtl/wrsc_ram.sv =====
module wrsc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/window_rect_screen_clamp_core.sv =====
// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+---------------------------------
// request   | in        | in_valid / in_ready | command, rect_*, fallback_*
// result    | out       | out_valid/out_ready | status, out_*, screen_index, on_screen
// config    | in        | cfg_we              | cfg_index, cfg_data
//
// clear, add and pass-through go via S_OUT back to idle; a place request walks the screens
// through S_OVRD, S_OVEDG, S_OVMUL and, if a valid candidate overlaps none, S_DSRD to S_DSY2,
// then S_TGRD, S_CLW, S_CLX, S_OUT; the single shared multiplier and one ram read port pace it
// arst_n resets the sequencer, screen count, config (minimums to 1) and result registers; ram is not cleared
// in_ready is low from acceptance until the sequencer is back in idle
// the result sits in its own register: a waiting result only holds the sequencer in its last
// cycle, and out_valid and the result hold while the receiver stalls
module window_rect_screen_clamp_core
	import wrsc_pkg::*;
#(
	parameter int MAX_SCREENS = DEF_MAX_SCREENS,
	parameter int COORD_BITS  = DEF_COORD_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [CFG_BITS-1:0]           cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [CMD_BITS-1:0]           command,
	input  logic signed [COORD_BITS-1:0]  rect_x,
	input  logic signed [COORD_BITS-1:0]  rect_y,
	input  logic signed [COORD_BITS-1:0]  rect_w,
	input  logic signed [COORD_BITS-1:0]  rect_h,
	input  logic signed [COORD_BITS-1:0]  fallback_x,
	input  logic signed [COORD_BITS-1:0]  fallback_y,
	input  logic signed [COORD_BITS-1:0]  fallback_w,
	input  logic signed [COORD_BITS-1:0]  fallback_h,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [STATUS_BITS-1:0]        status,
	output logic signed [COORD_BITS-1:0]  out_x,
	output logic signed [COORD_BITS-1:0]  out_y,
	output logic signed [COORD_BITS-1:0]  out_w,
	output logic signed [COORD_BITS-1:0]  out_h,
	output logic [IDX_OUT_BITS-1:0]       screen_index,
	output logic                          on_screen
);
	localparam int CB  = COORD_BITS;
	localparam int EB  = CB + 3;          // coordinate sums and differences
	localparam int PB  = 2 * EB + 2;      // products and squared distances
	localparam int IB  = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;
	localparam int NB  = $clog2(MAX_SCREENS + 1);
	localparam int RW  = 4 * CB;
	localparam logic [NB-1:0] N_MAX = NB'(MAX_SCREENS);

	// sequencer codes
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_OVRD  = 4'd1;   // overlap walk: ram read issued
	localparam logic [3:0] S_OVEDG = 4'd2;   // overlap spans registered
	localparam logic [3:0] S_OVMUL = 4'd3;   // multiply and compare
	localparam logic [3:0] S_DSRD  = 4'd4;
	localparam logic [3:0] S_DSDX  = 4'd5;   // dx, dy
	localparam logic [3:0] S_DSX2  = 4'd6;   // dx squared
	localparam logic [3:0] S_DSY2  = 4'd7;   // dy squared, sum, compare
	localparam logic [3:0] S_TGRD  = 4'd8;   // read chosen screen
	localparam logic [3:0] S_CLW   = 4'd9;   // target screen registered
	localparam logic [3:0] S_CLX   = 4'd10;  // size clamp, then position clamp
	localparam logic [3:0] S_OUT   = 4'd11;

	logic [3:0] state_q;
	logic [NB-1:0] count_q;
	logic [CFG_BITS-1:0] min_w_q, min_h_q;
	logic [IB-1:0] idx_q, sel_q;
	logic signed [EB-1:0] cx_q, cy_q, cw_q, ch_q;  // candidate
	logic signed [EB-1:0] px_q, py_q;              // candidate centre
	logic signed [EB-1:0] ea_q, eb_q;              // overlap spans or dx, dy
	logic signed [PB-1:0] prod_q, best_q;
	logic signed [EB-1:0] tx_q, ty_q, tw_q, th_q;
	logic signed [EB-1:0] w_q, h_q, x_q, y_q;
	logic hit_q;

	// result being built
	logic [STATUS_BITS-1:0] status_q;
	logic signed [CB-1:0] ox_q, oy_q, ow_q, oh_q;
	logic [IDX_OUT_BITS-1:0] oidx_q;
	logic oon_q, ovalid_q;

	// output register
	logic [STATUS_BITS-1:0] res_status_q;
	logic signed [CB-1:0] res_x_q, res_y_q, res_w_q, res_h_q;
	logic [IDX_OUT_BITS-1:0] res_idx_q;
	logic res_on_q;

	// screen ram
	logic ram_we;
	logic [IB-1:0] ram_waddr, ram_raddr;
	logic [RW-1:0] ram_wdata, ram_rdata;

	wrsc_ram #(.WIDTH(RW), .DEPTH(MAX_SCREENS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic signed [EB-1:0] sx, sy, sw, sh;
	assign sx = EB'($signed(ram_rdata[RW-1 -: CB]));
	assign sy = EB'($signed(ram_rdata[3*CB-1 -: CB]));
	assign sw = EB'($signed(ram_rdata[2*CB-1 -: CB]));
	assign sh = EB'($signed(ram_rdata[CB-1:0]));

	logic accept;
	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);

	logic req_ok, fb_ok;
	assign req_ok = (rect_w > 0) && (rect_h > 0);
	assign fb_ok  = (fallback_w > 0) && (fallback_h > 0);

	logic cand_ok;
	assign cand_ok = (cw_q > 0) && (ch_q > 0);

	assign ram_we    = accept && (command == CMD_ADD) && req_ok && (count_q < N_MAX);
	assign ram_waddr = count_q[IB-1:0];
	assign ram_wdata = {rect_x, rect_y, rect_w, rect_h};
	assign ram_raddr = (state_q == S_TGRD || state_q == S_CLW) ? sel_q : idx_q;

	// shared arithmetic: overlap spans, distances and the single multiplier
	logic signed [EB-1:0] lo_x, hi_x, lo_y, hi_y, span_x, span_y, ddx, ddy;
	logic signed [EB-1:0] mul_a, mul_b;
	logic signed [PB-1:0] mul_p;
	always_comb begin
		lo_x = (cx_q > sx) ? cx_q : sx;
		lo_y = (cy_q > sy) ? cy_q : sy;
		hi_x = ((cx_q + cw_q) < (sx + sw)) ? (cx_q + cw_q) : (sx + sw);
		hi_y = ((cy_q + ch_q) < (sy + sh)) ? (cy_q + ch_q) : (sy + sh);
		span_x = (hi_x > lo_x) ? (hi_x - lo_x) : '0;
		span_y = (hi_y > lo_y) ? (hi_y - lo_y) : '0;
		ddx = (px_q < sx) ? (sx - px_q) : ((px_q > sx + sw - 1) ? (px_q - (sx + sw - 1)) : '0);
		ddy = (py_q < sy) ? (sy - py_q) : ((py_q > sy + sh - 1) ? (py_q - (sy + sh - 1)) : '0);
		mul_a = (state_q == S_DSY2) ? eb_q : ea_q;
		mul_b = (state_q == S_OVMUL) ? eb_q : mul_a;
		mul_p = PB'(mul_a) * PB'(mul_b);
	end

	// size and position clamp
	logic signed [EB-1:0] mw, mh, w0, h0, w1, h1, x0, y0, mx, my, x1, y1;
	always_comb begin
		mw = (tw_q < EB'($signed({1'b0, (min_w_q == '0) ? CFG_BITS'(1) : min_w_q})))
			? tw_q : EB'($signed({1'b0, (min_w_q == '0) ? CFG_BITS'(1) : min_w_q}));
		mh = (th_q < EB'($signed({1'b0, (min_h_q == '0) ? CFG_BITS'(1) : min_h_q})))
			? th_q : EB'($signed({1'b0, (min_h_q == '0) ? CFG_BITS'(1) : min_h_q}));
		w0 = (cw_q > 0) ? cw_q : mw;
		h0 = (ch_q > 0) ? ch_q : mh;
		w0 = (w0 < tw_q) ? w0 : tw_q;
		h0 = (h0 < th_q) ? h0 : th_q;
		w1 = (mw > w0) ? mw : w0;
		h1 = (mh > h0) ? mh : h0;
		// centre offset, truncating towards zero
		x0 = (hit_q && cand_ok) ? cx_q : tx_q + (tw_q - w_q) / 2;
		y0 = (hit_q && cand_ok) ? cy_q : ty_q + (th_q - h_q) / 2;
		mx = tx_q + tw_q - w_q;
		my = ty_q + th_q - h_q;
		x0 = (x0 < mx) ? x0 : mx;
		y0 = (y0 < my) ? y0 : my;
		x1 = (tx_q > x0) ? tx_q : x0;
		y1 = (ty_q > y0) ? ty_q : y0;
	end

	function automatic logic signed [CB-1:0] sat(input logic signed [EB-1:0] v);
		logic signed [EB-1:0] hi, lo;
		hi = EB'((2 ** (CB - 1)) - 1);
		lo = -hi - EB'(1);
		if (v > hi) begin
			return hi[CB-1:0];
		end
		if (v < lo) begin
			return lo[CB-1:0];
		end
		return v[CB-1:0];
	endfunction

	logic last_idx;
	assign last_idx = (NB'(idx_q) + NB'(1)) >= count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_w_q <= CFG_BITS'(1);
			min_h_q <= CFG_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_W: min_w_q <= cfg_data;
				CFG_MIN_H: min_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			ovalid_q <= 1'b0;
			idx_q <= '0; sel_q <= '0; hit_q <= 1'b0;
			prod_q <= '0; best_q <= '0;
			cx_q <= '0; cy_q <= '0; cw_q <= '0; ch_q <= '0;
			px_q <= '0; py_q <= '0; ea_q <= '0; eb_q <= '0;
			tx_q <= '0; ty_q <= '0; tw_q <= '0; th_q <= '0;
			w_q <= '0; h_q <= '0; x_q <= '0; y_q <= '0;
			status_q <= ST_PLACED;
			ox_q <= '0; oy_q <= '0; ow_q <= '0; oh_q <= '0;
			oidx_q <= '0; oon_q <= 1'b0;
			res_status_q <= ST_PLACED;
			res_x_q <= '0; res_y_q <= '0; res_w_q <= '0; res_h_q <= '0;
			res_idx_q <= '0; res_on_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						sel_q <= '0;
						hit_q <= 1'b0;
						best_q <= '0;
						status_q <= ST_PLACED;
						ox_q <= '0; oy_q <= '0; ow_q <= '0; oh_q <= '0;
						oidx_q <= '0; oon_q <= 1'b0;
						if (command == CMD_CLEAR) begin
							count_q <= '0;
							status_q <= ST_CLEARED;
							state_q <= S_OUT;
						end else if (command == CMD_ADD) begin
							if (!req_ok) begin
								status_q <= ST_INVALID;
							end else if (count_q >= N_MAX) begin
								status_q <= ST_FULL;
							end else begin
								status_q <= ST_ADDED;
								oidx_q <= IDX_OUT_BITS'(count_q);
								count_q <= count_q + NB'(1);
							end
							state_q <= S_OUT;
						end else begin
							if (!req_ok && fb_ok) begin
								cx_q <= EB'(fallback_x); cy_q <= EB'(fallback_y);
								cw_q <= EB'(fallback_w); ch_q <= EB'(fallback_h);
								px_q <= EB'(fallback_x) + EB'(fallback_w / 2);
								py_q <= EB'(fallback_y) + EB'(fallback_h / 2);
							end else begin
								cx_q <= EB'(rect_x); cy_q <= EB'(rect_y);
								cw_q <= EB'(rect_w); ch_q <= EB'(rect_h);
								px_q <= EB'(rect_x) + EB'(rect_w / 2);
								py_q <= EB'(rect_y) + EB'(rect_h / 2);
							end
							if (count_q == '0) begin
								status_q <= ST_PASS;
								if (!req_ok && fb_ok) begin
									ox_q <= fallback_x; oy_q <= fallback_y;
									ow_q <= fallback_w; oh_q <= fallback_h;
								end else begin
									ox_q <= rect_x; oy_q <= rect_y;
									ow_q <= rect_w; oh_q <= rect_h;
								end
								state_q <= S_OUT;
							end else begin
								state_q <= S_OVRD;
							end
						end
					end
				end
				S_OVRD: state_q <= S_OVEDG;
				S_OVEDG: begin
					ea_q <= cand_ok ? span_x : '0;
					eb_q <= cand_ok ? span_y : '0;
					state_q <= S_OVMUL;
				end
				S_OVMUL: begin
					if (mul_p > best_q) begin
						best_q <= mul_p;
						sel_q <= idx_q;
						hit_q <= 1'b1;
					end
					if (last_idx) begin
						idx_q <= '0;
						state_q <= (mul_p > best_q || hit_q || !cand_ok) ? S_TGRD : S_DSRD;
						best_q <= {1'b0, {(PB-1){1'b1}}};
					end else begin
						idx_q <= idx_q + IB'(1);
						state_q <= S_OVRD;
					end
				end
				S_DSRD: state_q <= S_DSDX;
				S_DSDX: begin
					ea_q <= ddx;
					eb_q <= ddy;
					state_q <= S_DSX2;
				end
				S_DSX2: begin
					prod_q <= mul_p;
					state_q <= S_DSY2;
				end
				S_DSY2: begin
					if (prod_q + mul_p < best_q) begin
						best_q <= prod_q + mul_p;
						sel_q <= idx_q;
					end
					if (last_idx) begin
						state_q <= S_TGRD;
					end else begin
						idx_q <= idx_q + IB'(1);
						state_q <= S_DSRD;
					end
				end
				S_TGRD: state_q <= S_CLW;
				S_CLW: begin
					tx_q <= sx; ty_q <= sy; tw_q <= sw; th_q <= sh;
					state_q <= S_CLX;
				end
				S_CLX: begin
					if (w_q == '0 && h_q == '0) begin
						// first pass latches the size, second the position
						w_q <= w1;
						h_q <= h1;
					end else begin
						x_q <= x1;
						y_q <= y1;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!ovalid_q) begin
						ovalid_q <= 1'b1;
						state_q <= S_IDLE;
						res_status_q <= status_q;
						if (status_q == ST_PLACED) begin
							res_x_q <= sat(x_q); res_y_q <= sat(y_q);
							res_w_q <= sat(w_q); res_h_q <= sat(h_q);
							res_idx_q <= IDX_OUT_BITS'(sel_q);
							res_on_q <= hit_q;
						end else begin
							res_x_q <= ox_q; res_y_q <= oy_q;
							res_w_q <= ow_q; res_h_q <= oh_q;
							res_idx_q <= oidx_q;
							res_on_q <= oon_q;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_CLW) begin
				w_q <= '0;
				h_q <= '0;
			end
		end
	end

	assign out_valid    = ovalid_q;
	assign status       = res_status_q;
	assign out_x        = res_x_q;
	assign out_y        = res_y_q;
	assign out_w        = res_w_q;
	assign out_h        = res_h_q;
	assign screen_index = res_idx_q;
	assign on_screen    = res_on_q;
endmodule

// ===== rtl/wrsc_checker.sv =====
`include "window_rect_screen_clamp_core_macros.svh"
module wrsc_checker
	import wrsc_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [STATUS_BITS-1:0] status,
	input logic                   on_screen
);
	`WRSC_ASSERT_IMP(a_status_range, out_valid, status <= ST_CLEARED)
	`WRSC_ASSERT_NEXT(a_hold_stall, out_valid && !out_ready, out_valid && $stable(status))
	`WRSC_ASSERT_NEXT(a_no_back_accept, in_valid && in_ready, !in_ready)
	`WRSC_ASSERT_IMP(a_on_screen_placed, out_valid && on_screen, status == ST_PLACED)
endmodule

bind window_rect_screen_clamp_core wrsc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status), .on_screen(on_screen)
);
